[design/lpft_pkg.sv]
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared constants, codes and types of the linear-probe fingerprint table.
// ----------------------------------------------------------------------------
package lpft_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;

    // capacity register
    localparam int CAP_W     = 13;
    localparam int CAP_RESET = 4096;

    // probe position / probe count compare width
    localparam int CMP_W = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;

    // splitmix64
    localparam logic [KEY_W-1:0] MIX_C1 = 64'h9E3779B97F4A7C15;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'hBF58476D1CE4E5B9;
    localparam logic [KEY_W-1:0] MIX_C3 = 64'h94D049BB133111EB;
    localparam int MIX_S1 = 30;
    localparam int MIX_S2 = 27;
    localparam int MIX_S3 = 31;

    // remainder unit: dividend width and bits retired per cycle
    localparam int DIV_W     = 32;
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = DIV_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_HASH,
        CS_MOD,
        CS_PROBE,
        CS_OUT
    } core_state_t;

    typedef enum logic [1:0] {
        PR_CLEAR,
        PR_IDLE,
        PR_CHECK
    } probe_state_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] fp;
        logic [VAL_W-1:0] val;
    } slot_t;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  fp;
        logic [VAL_W-1:0]  val;
        logic [ADDR_W-1:0] pos;
    } probe_req_t;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] value;
    } probe_rsp_t;

endpackage

[design/lpft_if.sv]
// ----------------------------------------------------------------------------
// lpft_if
// Valid/ready channels of the fingerprint table: request and response.
// ----------------------------------------------------------------------------
interface lpft_req_if;
    import lpft_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [KEY_W-1:0] key_word;
    logic [VAL_W-1:0] value_in;

    modport source (output valid, output func, output key_word, output value_in,
                    input ready);
    modport sink   (input valid, input func, input key_word, input value_in,
                    output ready);
endinterface

interface lpft_rsp_if;
    import lpft_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink   (input valid, input status, input value_out, output ready);
endinterface

[design/lpft_hash.sv]
// ----------------------------------------------------------------------------
// lpft_hash
// splitmix64 on one shared 32x32 multiplier; each 64-bit product mod 2^64 is
// built from low*low, then the two cross terms into the upper half.
// ----------------------------------------------------------------------------
module lpft_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lpft_pkg::KEY_W-1:0] key_word,
    output logic                       done,
    output logic [lpft_pkg::KEY_W-1:0] fp
);
    import lpft_pkg::*;

    localparam int HALF = KEY_W / 2;

    logic             busy_reg;
    logic             pass_reg;
    logic             done_reg;
    logic [1:0]       step_reg;
    logic [KEY_W-1:0] a_reg;
    logic [KEY_W-1:0] acc_reg;
    logic [KEY_W-1:0] prod_reg;
    logic [KEY_W-1:0] fp_reg;

    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] mul_b;
    logic [HALF-1:0]  mul_x;
    logic [HALF-1:0]  mul_y;
    logic [KEY_W-1:0] mul_p;
    logic [HALF-1:0]  acc_hi_sum;
    logic [KEY_W-1:0] prod_sum;

    assign k0    = key_word + MIX_C1;
    assign mul_b = pass_reg ? MIX_C3 : MIX_C2;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_x = a_reg[HALF-1:0];
                mul_y = mul_b[HALF-1:0];
            end
            2'd1:
            begin
                mul_x = a_reg[HALF-1:0];
                mul_y = mul_b[KEY_W-1:HALF];
            end
            default:
            begin
                mul_x = a_reg[KEY_W-1:HALF];
                mul_y = mul_b[HALF-1:0];
            end
        endcase
    end

    assign mul_p      = KEY_W'(mul_x) * KEY_W'(mul_y);
    // cross terms only reach the upper half of the truncated product
    assign acc_hi_sum = acc_reg[KEY_W-1:HALF] + prod_reg[HALF-1:0];
    assign prod_sum   = {acc_hi_sum, acc_reg[HALF-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pass_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                pass_reg <= 1'b0;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    if (!pass_reg)
                    begin
                        pass_reg <= 1'b1;
                    end
                    else
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= k0 ^ (k0 >> MIX_S1);
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:
                begin
                    prod_reg <= mul_p;
                end
                2'd1:
                begin
                    acc_reg  <= prod_reg;
                    prod_reg <= mul_p;
                end
                2'd2:
                begin
                    acc_reg[KEY_W-1:HALF] <= acc_hi_sum;
                    prod_reg              <= mul_p;
                end
                default:
                begin
                    if (!pass_reg)
                    begin
                        a_reg <= prod_sum ^ (prod_sum >> MIX_S2);
                    end
                    else
                    begin
                        fp_reg <= prod_sum ^ (prod_sum >> MIX_S3);
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign fp   = fp_reg;

endmodule

[design/lpft_mod.sv]
// ----------------------------------------------------------------------------
// lpft_mod
// Restoring remainder unit: 32-bit dividend mod capacity, MOD_BITS per cycle.
// ----------------------------------------------------------------------------
module lpft_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpft_pkg::DIV_W-1:0]  dividend,
    input  logic [lpft_pkg::CAP_W-1:0]  cap,
    output logic                        done,
    output logic [lpft_pkg::ADDR_W-1:0] rem
);
    import lpft_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [CAP_W-1:0]     rem_reg;
    logic [CAP_W-1:0]     rem_next;

    // remainder stays below cap, so one compare-subtract per bit suffices
    always_comb
    begin
        logic [CAP_W:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {rem_next, quo_reg[DIV_W-1-i]};
            if (t >= {1'b0, cap})
            begin
                t = t - {1'b0, cap};
            end
            rem_next = t[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + MOD_CNT_W'(1);
                if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_reg << MOD_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = ADDR_W'(rem_reg);

endmodule

[design/lpft_probe.sv]
// ----------------------------------------------------------------------------
// lpft_probe
// Slot memory and linear-probe sequencer. One slot is checked per cycle while
// the next slot is being read. Clears the used marks after reset.
// ----------------------------------------------------------------------------
module lpft_probe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  lpft_pkg::probe_req_t       req,
    input  logic [lpft_pkg::CAP_W-1:0] cap,
    output logic                       ready,
    output logic                       done,
    output lpft_pkg::probe_rsp_t       rsp
);
    import lpft_pkg::*;

    slot_t mem [TABLE_DEPTH];

    probe_state_t      state_reg;
    probe_state_t      state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [CMP_W-1:0]  cnt_reg;
    logic              func_reg;
    logic [KEY_W-1:0]  fp_reg;
    logic [VAL_W-1:0]  val_reg;
    slot_t             rd_data_reg;
    logic              done_reg;
    probe_rsp_t        rsp_reg;

    logic [CMP_W-1:0]  pos_inc;
    logic [CMP_W-1:0]  cnt_inc;
    logic [ADDR_W-1:0] pos_adv;
    logic              last_probe;
    logic              finish;
    probe_rsp_t        rsp_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    slot_t             wr_data;
    logic [ADDR_W-1:0] rd_addr;

    assign pos_inc    = CMP_W'(pos_reg) + CMP_W'(1);
    assign cnt_inc    = cnt_reg + CMP_W'(1);
    assign pos_adv    = (pos_inc >= CMP_W'(cap)) ? '0 : ADDR_W'(pos_inc);
    assign last_probe = (cnt_inc == CMP_W'(cap));

    always_comb
    begin
        state_next       = state_reg;
        finish           = 1'b0;
        rsp_next.status  = ST_NOT_FOUND;
        rsp_next.value   = '0;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data.used     = 1'b1;
        wr_data.fp       = fp_reg;
        wr_data.val      = val_reg;
        rd_addr          = pos_adv;
        case (state_reg)
            PR_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = PR_IDLE;
                end
            end
            PR_IDLE:
            begin
                rd_addr = req.pos;
                if (start)
                begin
                    state_next = PR_CHECK;
                end
            end
            PR_CHECK:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (rd_data_reg.used && rd_data_reg.fp == fp_reg &&
                        rd_data_reg.val == val_reg)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_DUPLICATE;
                    end
                    else if (!rd_data_reg.used)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_INSERTED;
                        wr_en           = 1'b1;
                    end
                    else if (last_probe)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_FULL;
                    end
                end
                else
                begin
                    if (!rd_data_reg.used)
                    begin
                        finish = 1'b1;
                    end
                    else if (rd_data_reg.fp == fp_reg)
                    begin
                        finish          = 1'b1;
                        rsp_next.status = ST_FOUND;
                        rsp_next.value  = rd_data_reg.val;
                    end
                    else if (last_probe)
                    begin
                        finish = 1'b1;
                    end
                end
                if (finish)
                begin
                    state_next = PR_IDLE;
                end
            end
            default:
            begin
                state_next = PR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PR_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == PR_CHECK) && finish;
            if (state_reg == PR_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == PR_IDLE && start)
        begin
            func_reg <= req.func;
            fp_reg   <= req.fp;
            val_reg  <= req.val;
            pos_reg  <= req.pos;
            cnt_reg  <= '0;
        end
        else if (state_reg == PR_CHECK && !finish)
        begin
            pos_reg <= pos_adv;
            cnt_reg <= cnt_inc;
        end
        if (state_reg == PR_CHECK && finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign ready = (state_reg == PR_IDLE);
    assign done  = done_reg;
    assign rsp   = rsp_reg;

endmodule

[design/linear_probe_fingerprint_table_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_fingerprint_table_core
// Open-addressing fingerprint table with splitmix64 keys and linear probing.
// ----------------------------------------------------------------------------
// One item at a time. After a request transfer the key is hashed (two 64-bit
// products, each built from three partial products on one 32x32 multiplier),
// the start slot is formed by a remainder unit that retires four dividend
// bits per cycle, and the slot memory is then probed at one slot per cycle
// behind a registered read, from one slot up to the capacity. After reset
// the used marks are swept clear, one slot per cycle, over all TABLE_DEPTH
// (4096) slots, during which no request is taken; capacity writes are taken
// at any time. The response sits in an output register, so the next request
// is taken while it waits.
module linear_probe_fingerprint_table_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lpft_pkg::CAP_W-1:0] cfg_wr_data,
    lpft_req_if.sink                   req,
    lpft_rsp_if.source                 rsp
);
    import lpft_pkg::*;

    core_state_t      state_reg;
    core_state_t      state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_live;
    logic             func_reg;
    logic [VAL_W-1:0] val_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          out_status_reg;
    logic [VAL_W-1:0] out_value_reg;

    logic              accept;
    logic              out_load;
    logic              hash_done;
    logic [KEY_W-1:0]  hash_fp;
    logic              mod_start;
    logic              mod_done;
    logic [ADDR_W-1:0] mod_rem;
    logic              probe_start;
    logic              probe_ready;
    logic              probe_done;
    probe_req_t        probe_req;
    probe_rsp_t        probe_rsp;

    // zero acts as one, anything above the table depth is clamped
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_live = CAP_W'(1);
        end
        else if (32'(cap_reg) > TABLE_DEPTH)
        begin
            cap_live = CAP_W'(TABLE_DEPTH);
        end
        else
        begin
            cap_live = cap_reg;
        end
    end

    assign req.ready = (state_reg == CS_IDLE) && probe_ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        mod_start      = 1'b0;
        probe_start    = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = CS_HASH;
                end
            end
            CS_HASH:
            begin
                if (hash_done)
                begin
                    mod_start  = 1'b1;
                    state_next = CS_MOD;
                end
            end
            CS_MOD:
            begin
                if (mod_done)
                begin
                    probe_start = 1'b1;
                    state_next  = CS_PROBE;
                end
            end
            CS_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = CS_OUT;
                end
            end
            CS_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            cap_reg       <= CAP_W'(CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            val_reg  <= req.value_in;
        end
        if (out_load)
        begin
            out_status_reg <= probe_rsp.status;
            out_value_reg  <= probe_rsp.value;
        end
    end

    assign probe_req.func = func_reg;
    assign probe_req.fp   = hash_fp;
    assign probe_req.val  = val_reg;
    assign probe_req.pos  = mod_rem;

    lpft_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .key_word (req.key_word),
        .done     (hash_done),
        .fp       (hash_fp)
    );

    lpft_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_fp[DIV_W-1:0]),
        .cap      (cap_live),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    lpft_probe u_probe (
        .clk   (clk),
        .rst_n (rst_n),
        .start (probe_start),
        .req   (probe_req),
        .cap   (cap_live),
        .ready (probe_ready),
        .done  (probe_done),
        .rsp   (probe_rsp)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;

endmodule

[design/lpft_checker.sv]
// ----------------------------------------------------------------------------
// lpft_checker
// Port-level checks of the fingerprint table, bound to the top level.
// ----------------------------------------------------------------------------
module lpft_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [lpft_pkg::STATUS_W-1:0] rsp_status,
    input  logic [lpft_pkg::VAL_W-1:0]    rsp_value_out
);
    import lpft_pkg::*;

    // a pending response is held until its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    // value is only reported on a hit
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_FOUND |-> rsp_value_out == '0)
        else $error("nonzero value without a hit");

    // one item in flight: busy right after a request transfer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    // a new response is only produced while the request side is busy
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared while idle");

endmodule

bind linear_probe_fingerprint_table_core lpft_checker u_lpft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_value_out (rsp.value_out)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the fingerprint table core against a shadow copy of the table.
// Each request is hashed and probed in the shadow at its transfer. Responses
// are compared in order. Directed tests cover the single-slot table, a short
// wrap, capacity clamping and the all-zero/all-one keys and values. Random
// phases then mix inserts, duplicates and finds under changing capacities.
// ----------------------------------------------------------------------------
module testbench;
    import lpft_pkg::*;

    typedef struct {
        status_t          status;
        logic [VAL_W-1:0] value;
    } lookup_result_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } pair_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    lpft_req_if req_ch ();
    lpft_rsp_if rsp_ch ();

    linear_probe_fingerprint_table_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // shadow of the table and the capacity register
    bit               shadow_used [TABLE_DEPTH];
    logic [KEY_W-1:0] shadow_fp   [TABLE_DEPTH];
    logic [VAL_W-1:0] shadow_val  [TABLE_DEPTH];
    logic [CAP_W-1:0] shadow_capacity = CAP_W'(CAP_RESET);

    lookup_result_t pending_lookups[$];
    pair_t          known_pairs[$];
    int             mismatch_count = 0;
    int             items_sent     = 0;
    int             req_gap_max    = 14;
    int             rsp_gap_max    = 14;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] splitmix_fp(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] z;
        z = key + MIX_C1;
        z = (z ^ (z >> MIX_S1)) * MIX_C2;
        z = (z ^ (z >> MIX_S2)) * MIX_C3;
        return z ^ (z >> MIX_S3);
    endfunction

    function automatic lookup_result_t probe_table(input logic op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] val);
        lookup_result_t   r;
        logic [KEY_W-1:0] fp;
        int unsigned      lim;
        int unsigned      pos;
        fp  = splitmix_fp(key);
        lim = (shadow_capacity == 0) ? 1 :
              (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : shadow_capacity;
        pos = fp[31:0] % lim;
        r.value = '0;
        if (op == FUNC_INSERT)
        begin
            r.status = ST_FULL;
            for (int unsigned n = 0; n < lim; n++)
            begin
                if (!shadow_used[pos])
                begin
                    shadow_used[pos] = 1'b1;
                    shadow_fp[pos]   = fp;
                    shadow_val[pos]  = val;
                    r.status = ST_INSERTED;
                    break;
                end
                // same fingerprint with another value keeps probing
                if (shadow_fp[pos] == fp && shadow_val[pos] == val)
                begin
                    r.status = ST_DUPLICATE;
                    break;
                end
                pos = (pos + 1 == lim) ? 0 : pos + 1;
            end
        end
        else
        begin
            r.status = ST_NOT_FOUND;
            for (int unsigned n = 0; n < lim; n++)
            begin
                if (!shadow_used[pos])
                    break;
                if (shadow_fp[pos] == fp)
                begin
                    r.status = ST_FOUND;
                    r.value  = shadow_val[pos];
                    break;
                end
                pos = (pos + 1 == lim) ? 0 : pos + 1;
            end
        end
        return r;
    endfunction

    // one request transfer; valid stays high afterwards until the next call idles or settle drops it
    task automatic issue_request(input logic op, input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] val);
        int gap;
        gap = $urandom_range(req_gap_max);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.key_word <= key;
        req_ch.value_in <= val;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_lookups.push_back(probe_table(op, key, val));
        items_sent++;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_capacity = cap;
    endtask

    // response side: random stall, then take one transfer and compare
    initial
    begin
        int             stall;
        lookup_result_t want;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(rsp_gap_max);
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
            if (pending_lookups.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d value %h", $time,
                         rsp_ch.status, rsp_ch.value_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.value_out !== want.value)
                begin
                    $display("%0t: value_out expected %h actual %h", $time,
                             want.value, rsp_ch.value_out);
                    mismatch_count++;
                end
            end
        end
    end

    // reset value of the capacity register
    task automatic test_reset_capacity();
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        k = {$urandom, $urandom};
        v = {$urandom, $urandom};
        issue_request(FUNC_INSERT, k, v);
        issue_request(FUNC_FIND, k, '0);
    endtask

    // capacity zero acts as one slot: duplicate, full and not-found paths
    task automatic test_single_slot();
        logic [KEY_W-1:0] k1, k2;
        logic [VAL_W-1:0] v1;
        k1 = {$urandom, $urandom};
        k2 = {$urandom, $urandom};
        v1 = {$urandom, $urandom};
        write_capacity(CAP_W'(0));
        issue_request(FUNC_INSERT, k1, v1);
        issue_request(FUNC_INSERT, k1, v1);
        issue_request(FUNC_INSERT, k1, ~v1);
        issue_request(FUNC_FIND, k1, '0);
        issue_request(FUNC_FIND, k2, v1);
        issue_request(FUNC_INSERT, k2, v1);
        write_capacity(CAP_W'(1));
        issue_request(FUNC_FIND, k1, '1);
    endtask

    // three slots: fill, overflow, wrapped search
    task automatic test_short_wrap();
        logic [KEY_W-1:0] first;
        first = {$urandom, $urandom};
        write_capacity(CAP_W'(3));
        issue_request(FUNC_INSERT, first, {$urandom, $urandom});
        repeat (3) issue_request(FUNC_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
        issue_request(FUNC_FIND, {$urandom, $urandom}, '0);
        issue_request(FUNC_FIND, first, '0);
    endtask

    // capacity above depth is clamped; extreme keys and values
    task automatic test_clamped_capacity();
        write_capacity('1);
        issue_request(FUNC_INSERT, '0, '0);
        issue_request(FUNC_INSERT, '1, '1);
        issue_request(FUNC_FIND, '0, '1);
        issue_request(FUNC_FIND, '1, '0);
        issue_request(FUNC_INSERT, '0, '0);
        issue_request(FUNC_FIND, {$urandom, $urandom}, '0);
        write_capacity(CAP_W'(TABLE_DEPTH));
        issue_request(FUNC_FIND, '1, '0);
        issue_request(FUNC_INSERT, '1, '0);
    endtask

    task automatic random_item();
        int unsigned      sel;
        pair_t            p;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        sel = $urandom_range(99);
        k   = {$urandom, $urandom};
        v   = {$urandom, $urandom};
        if (known_pairs.size() != 0)
            p = known_pairs[$urandom_range(known_pairs.size() - 1)];
        else
        begin
            p.key = k;
            p.val = v;
        end
        if (sel < 35)
        begin
            issue_request(FUNC_INSERT, k, v);
            known_pairs.push_back('{k, v});
        end
        else if (sel < 50)
            issue_request(FUNC_INSERT, p.key, p.val);
        else if (sel < 60)
        begin
            issue_request(FUNC_INSERT, p.key, v);
            known_pairs.push_back('{p.key, v});
        end
        else if (sel < 85)
            issue_request(FUNC_FIND, p.key, v);
        else
            issue_request(FUNC_FIND, k, v);
        if (known_pairs.size() > 256)
            void'(known_pairs.pop_front());
    endtask

    // phases of random traffic; large capacities get short phases
    task automatic test_random_traffic();
        int unsigned kind;
        int          count;
        while (items_sent < 1000)
        begin
            kind  = $urandom_range(9);
            count = 100;
            if (kind < 3)
                write_capacity(CAP_W'($urandom_range(16, 1)));
            else if (kind < 8)
                write_capacity(CAP_W'($urandom_range(300, 17)));
            else
            begin
                write_capacity((kind == 8) ? CAP_W'(TABLE_DEPTH) :
                               CAP_W'($urandom_range(8191, 4097)));
                count = 30;
            end
            req_gap_max = $urandom_range(1) ? 14 : 0;
            rsp_gap_max = $urandom_range(1) ? 14 : 0;
            repeat (count) random_item();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FUNC_INSERT;
        req_ch.key_word <= '0;
        req_ch.value_in <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_capacity();
        test_single_slot();
        test_short_wrap();
        test_clamped_capacity();
        test_random_traffic();
        settle();
        repeat (64) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

endmodule
